// ===== src/psac_pkg.sv =====
// ----------------------------------------------------------------------------
// psac_pkg
// Shared types, constants and helper functions of the pileup site allele
// classifier.
// ----------------------------------------------------------------------------
package psac_pkg;

  localparam int COUNT_MAX   = 1023;
  localparam int CHROM_COUNT = 256;
  localparam int CNT_W       = $clog2(COUNT_MAX + 1);
  localparam int OUT_CNT_W   = 10;
  localparam int QUAL_OFFSET = 33;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_N = 3'd4;

  localparam logic [1:0] ST_UNRES = 2'd0;
  localparam logic [1:0] ST_REF   = 2'd1;
  localparam logic [1:0] ST_ALT   = 2'd2;

  localparam logic REG_MIN_QUAL = 1'b0;
  localparam logic REG_QC_FAIL  = 1'b1;

  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    CMD_FLUSH,
    CMD_SITE,
    CMD_EMPTY,
    CMD_DROP
  } cmd_op_t;

  typedef struct packed {
    logic [7:0]       chrom;
    logic [31:0]      pos;
    logic [2:0]       ref_b;
    logic [2:0]       alt;
    logic [1:0]       chimp;
    logic [1:0]       anc;
    logic             epo;
    logic [CNT_W-1:0] cref;
    logic [CNT_W-1:0] calt;
  } site_rec_t;

  typedef struct packed {
    cmd_op_t   op;
    logic      had_c;
    site_rec_t rec;
  } cmd_t;

  typedef struct packed {
    site_rec_t rec;
    logic      cpg;
    logic      last;
  } out_ent_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] alt;
    logic [1:0] st;
  } class_t;

  function automatic logic [2:0] base_code(input logic [2:0] b);
    base_code = (b > BASE_N) ? BASE_N : b;
  endfunction

  function automatic class_t classify(input logic [2:0] allele, input logic [2:0] ref_b,
                                      input logic [2:0] alt);
    class_t c;
    c.ok  = 1'b1;
    c.alt = alt;
    c.st  = ST_UNRES;
    priority if (allele >= BASE_N) begin
      c.st = ST_UNRES;
    end else if (allele == ref_b) begin
      c.st = ST_REF;
    end else if (alt == BASE_N) begin
      c.alt = allele;
      c.st  = ST_ALT;
    end else if (alt == allele) begin
      c.st = ST_ALT;
    end else begin
      c.ok = 1'b0;
    end
    return c;
  endfunction

endpackage

// ===== src/psac_front.sv =====
// ----------------------------------------------------------------------------
// psac_front
// Config registers, base filtering, per-site counting and allele
// classification; issues one command per finished site that is not ignored, or per flush.
// ----------------------------------------------------------------------------
module psac_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psac_pkg::CFG_AW-1:0]   paddr,
  input  logic [psac_pkg::CFG_DW-1:0]   pwdata,
  output logic [psac_pkg::CFG_DW-1:0]   prdata,
  input  logic                          push,
  input  logic                          q_full,
  input  logic                          in_req_type,
  input  logic [7:0]                    in_chrom_id,
  input  logic [31:0]                   in_site_pos,
  input  logic [2:0]                    in_ref_base,
  input  logic [2:0]                    in_read_base,
  input  logic [7:0]                    in_raw_qual,
  input  logic                          in_failed_qc,
  input  logic                          in_del_then_ins,
  input  logic [2:0]                    in_chimp_base,
  input  logic [2:0]                    in_anc_base,
  input  logic                          in_epo_cpg,
  input  logic                          in_site_last,
  output logic                          cmd_push,
  output psac_pkg::cmd_t                cmd
);
  import psac_pkg::*;

  logic [7:0]       minq_r;
  logic             qcf_r;
  logic [CNT_W-1:0] cref_r, cref_nxt;
  logic [CNT_W-1:0] calt_r, calt_nxt;
  logic [2:0]       alt_r, alt_nxt;
  logic             tri_r, tri_nxt;

  logic [2:0] refb, rb, cb, ab, alt_fin;
  logic [7:0] q;
  logic       accept, flush, ignore, cnt_ok, empty_site;
  class_t     cls_c, cls_a;
  logic       cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_QC_FAIL) ? {{(CFG_DW-1){1'b0}}, qcf_r}
                                             : {{(CFG_DW-8){1'b0}}, minq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minq_r <= 8'd0;
      qcf_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_QUAL) minq_r <= pwdata[7:0];
      else qcf_r <= pwdata[0];
    end
  end

  assign refb   = base_code(in_ref_base);
  assign rb     = base_code(in_read_base);
  assign cb     = base_code(in_chimp_base);
  assign ab     = base_code(in_anc_base);
  assign accept = push && !q_full;
  assign flush  = (in_req_type == REQ_FLUSH);
  assign ignore = (refb == BASE_N) || ({1'b0, in_chrom_id} >= 9'(CHROM_COUNT));
  assign q      = in_raw_qual - 8'(QUAL_OFFSET);
  assign cnt_ok = !tri_r && !(in_failed_qc && !qcf_r) && !in_del_then_ins &&
                  ($signed(q) >= $signed(minq_r));

  always_comb begin
    cref_nxt = cref_r;
    calt_nxt = calt_r;
    alt_nxt  = alt_r;
    tri_nxt  = tri_r;
    if (cnt_ok) begin
      priority if (rb == refb) begin
        if (cref_r != CNT_W'(COUNT_MAX)) cref_nxt = cref_r + 1'b1;
      end else if (alt_r == BASE_N) begin
        alt_nxt = rb;
        if (calt_r != CNT_W'(COUNT_MAX)) calt_nxt = calt_r + 1'b1;
      end else if (rb == alt_r) begin
        if (calt_r != CNT_W'(COUNT_MAX)) calt_nxt = calt_r + 1'b1;
      end else begin
        tri_nxt = 1'b1;
      end
    end
  end

  assign empty_site = (cref_nxt == '0) && (calt_nxt == '0);
  assign cls_c      = classify(cb, refb, alt_nxt);
  assign cls_a      = classify(ab, refb, cls_c.alt);
  assign alt_fin    = (!tri_nxt && !empty_site && cls_c.ok) ? cls_a.alt : alt_nxt;

  always_comb begin
    cmd.rec.chrom = in_chrom_id;
    cmd.rec.pos   = in_site_pos;
    cmd.rec.ref_b = refb;
    cmd.rec.alt   = alt_fin;
    cmd.rec.chimp = cls_c.st;
    cmd.rec.anc   = cls_a.st;
    cmd.rec.epo   = ((cb < BASE_N) || (ab < BASE_N)) ? in_epo_cpg : 1'b0;
    cmd.rec.cref  = cref_nxt;
    cmd.rec.calt  = calt_nxt;
    cmd.had_c     = (refb == BASE_C) || (alt_fin == BASE_C);
    priority if (flush) cmd.op = CMD_FLUSH;
    else if (tri_nxt) cmd.op = CMD_DROP;
    else if (empty_site) cmd.op = CMD_EMPTY;
    else if (!(cls_c.ok && cls_a.ok)) cmd.op = CMD_DROP;
    else cmd.op = CMD_SITE;
  end

  assign cmd_push = accept && (flush || (!ignore && in_site_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cref_r <= '0;
      calt_r <= '0;
      alt_r  <= BASE_N;
      tri_r  <= 1'b0;
    end else if (accept && !flush && !ignore) begin
      if (in_site_last) begin
        cref_r <= '0;
        calt_r <= '0;
        alt_r  <= BASE_N;
        tri_r  <= 1'b0;
      end else begin
        cref_r <= cref_nxt;
        calt_r <= calt_nxt;
        alt_r  <= alt_nxt;
        tri_r  <= tri_nxt;
      end
    end
  end

endmodule

// ===== src/psac_cmdq.sv =====
// ----------------------------------------------------------------------------
// psac_cmdq
// Small command queue between the classifying front and the release back.
// ----------------------------------------------------------------------------
module psac_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psac_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output psac_pkg::cmd_t dout,
  output logic           empty
);
  import psac_pkg::*;

  cmd_t             mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CQ_CW'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop) rd_nxt = (rd_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/psac_back.sv =====
// ----------------------------------------------------------------------------
// psac_back
// Holds one site record back, pairs adjacent C-G sites and queues the
// released records for the result side.
// ----------------------------------------------------------------------------
module psac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  psac_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output psac_pkg::out_ent_t head
);
  import psac_pkg::*;

  out_ent_t         oq [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, rd_r, wr1;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]       n_push;
  out_ent_t         e0, e1;

  logic      held_v_r, held_v_nxt;
  site_rec_t held_r, held_nxt;
  logic [31:0] prev_pos_r, prev_pos_nxt;
  logic      prev_c_r, prev_c_nxt;
  logic      take, pair, do_pop;

  assign take    = !cmd_empty && (cnt_r <= OQ_CW'(OQ_DEPTH - 2));
  assign cmd_pop = take;
  assign do_pop  = pop && !empty;
  assign empty   = (cnt_r == '0);
  assign head    = oq[rd_r];
  assign wr1     = wr_r + 1'b1;

  assign pair = held_v_r && (prev_pos_r == cmd.rec.pos - 32'd1) && prev_c_r &&
                ((cmd.rec.ref_b == BASE_G) || (cmd.rec.alt == BASE_G));

  always_comb begin
    n_push       = 2'd0;
    e0           = '{rec: held_r, cpg: 1'b0, last: 1'b1};
    e1           = '{rec: cmd.rec, cpg: 1'b1, last: 1'b1};
    held_v_nxt   = held_v_r;
    held_nxt     = held_r;
    prev_pos_nxt = prev_pos_r;
    prev_c_nxt   = prev_c_r;
    if (take) begin
      unique case (cmd.op)
        CMD_FLUSH, CMD_EMPTY: begin
          if (held_v_r) n_push = 2'd1;
          held_v_nxt = 1'b0;
        end
        CMD_SITE: begin
          if (pair) begin
            n_push     = 2'd2;
            e0.cpg     = 1'b1;
            e0.last    = 1'b0;
            held_v_nxt = 1'b0;
          end else begin
            if (held_v_r) n_push = 2'd1;
            held_v_nxt = 1'b1;
            held_nxt   = cmd.rec;
          end
        end
        CMD_DROP: begin
        end
        default: begin
        end
      endcase
      if (cmd.op != CMD_FLUSH) begin
        prev_pos_nxt = cmd.rec.pos;
        prev_c_nxt   = cmd.had_c;
      end
    end
    cnt_nxt = cnt_r + OQ_CW'(n_push) - OQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) oq[wr_r] <= e0;
    if (n_push == 2'd2) oq[wr1] <= e1;
    held_r     <= held_nxt;
    prev_pos_r <= prev_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= '0;
      rd_r     <= '0;
      cnt_r    <= '0;
      held_v_r <= 1'b0;
      prev_c_r <= 1'b0;
    end else begin
      wr_r     <= wr_r + OQ_AW'(n_push);
      rd_r     <= rd_r + OQ_AW'(do_pop);
      cnt_r    <= cnt_nxt;
      held_v_r <= held_v_nxt;
      prev_c_r <= prev_c_nxt;
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overfilled");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (cmd.op == CMD_FLUSH || cmd.op == CMD_EMPTY)) |=> !held_v_r)
    else $error("held record survived a release");

  a_site_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.op == CMD_SITE && !pair) |=> held_v_r)
    else $error("site record not held");

  a_pair_two: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cmd.op == CMD_SITE && pair) |=> (cnt_r >= OQ_CW'(2 - 1)) && !held_v_r)
    else $error("cpg pair not released");

endmodule

// ===== src/pileup_site_allele_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// pileup_site_allele_classifier_unit
// Builds per-site allele records from streamed read bases, holding one
// record back to mark adjacent C-G sites.
// ----------------------------------------------------------------------------
// channel   | handshake         | payload
// ----------+-------------------+------------------------------------------
// input     | push / full       | in_* read base or flush request
// result    | empty / pop       | out_* site record, up to two per request
// config    | psel/penable/...  | min_base_qual @0x0, use_qc_fail @0x4
//
// one request per cycle is accepted while full is low; the front updates
// counters and classifies in the accept cycle, the back releases up to two
// records per command into a four-entry result queue, popped one per cycle.
// every kept site is released once, so a run of C-G pairs still averages one
// result per site; a pair only bunches two results into one command.
// reset is synchronous, active low; no clearing pass.
// full rises when the two-entry command queue fills behind a stalled pop.
// ----------------------------------------------------------------------------
module pileup_site_allele_classifier_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psac_pkg::CFG_AW-1:0] paddr,
  input  logic [psac_pkg::CFG_DW-1:0] pwdata,
  output logic [psac_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_req_type,
  input  logic [7:0]                  in_chrom_id,
  input  logic [31:0]                 in_site_pos,
  input  logic [2:0]                  in_ref_base,
  input  logic [2:0]                  in_read_base,
  input  logic [7:0]                  in_raw_qual,
  input  logic                        in_failed_qc,
  input  logic                        in_del_then_ins,
  input  logic [2:0]                  in_chimp_base,
  input  logic [2:0]                  in_anc_base,
  input  logic                        in_epo_cpg,
  input  logic                        in_site_last,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_chrom,
  output logic [31:0]                 out_pos,
  output logic [2:0]                  out_ref,
  output logic [2:0]                  out_alt,
  output logic [1:0]                  out_chimp_state,
  output logic [1:0]                  out_anc_state,
  output logic                        out_epo_cpg,
  output logic [9:0]                  out_ref_count,
  output logic [9:0]                  out_alt_count,
  output logic                        out_cpg_mark,
  output logic                        out_run_last
);
  import psac_pkg::*;

  logic     cmd_push, cmd_pop, cmd_empty;
  cmd_t     cmd_in, cmd_out;
  out_ent_t head;

  assign pready = 1'b1;

  psac_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .push            (push),
    .q_full          (full),
    .in_req_type     (in_req_type),
    .in_chrom_id     (in_chrom_id),
    .in_site_pos     (in_site_pos),
    .in_ref_base     (in_ref_base),
    .in_read_base    (in_read_base),
    .in_raw_qual     (in_raw_qual),
    .in_failed_qc    (in_failed_qc),
    .in_del_then_ins (in_del_then_ins),
    .in_chimp_base   (in_chimp_base),
    .in_anc_base     (in_anc_base),
    .in_epo_cpg      (in_epo_cpg),
    .in_site_last    (in_site_last),
    .cmd_push        (cmd_push),
    .cmd             (cmd_in)
  );

  psac_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  psac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  assign out_chrom       = head.rec.chrom;
  assign out_pos         = head.rec.pos;
  assign out_ref         = head.rec.ref_b;
  assign out_alt         = head.rec.alt;
  assign out_chimp_state = head.rec.chimp;
  assign out_anc_state   = head.rec.anc;
  assign out_epo_cpg     = head.rec.epo;
  assign out_ref_count   = OUT_CNT_W'(head.rec.cref);
  assign out_alt_count   = OUT_CNT_W'(head.rec.calt);
  assign out_cpg_mark    = head.cpg;
  assign out_run_last    = head.last;

endmodule
